@@ hw/rtl/sem_pkg.sv @@
package sem_pkg;

	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;

	localparam int PIX_W   = 8;
	localparam int DIM_W   = 10;
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int COORD_W = 9;
	localparam int CFG_IDX_W = 1;

	localparam int SUM_W  = PIX_W + 2;
	localparam int SQ_W   = 2 * PIX_W;
	localparam int RAD_W  = SQ_W + 1;
	localparam int ROOT_W = (RAD_W + 1) / 2;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

	localparam logic [DIM_W-1:0] MIN_DIM = DIM_W'(3);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPDATE,
		S_GRAD,
		S_SQUARE,
		S_START,
		S_ROOT,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic cfg_wr;
		logic take;
		logic upd;
		logic grad;
		logic square;
		logic root_start;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic interior;
		logic root_done;
	} sts_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		if (v < MIN_DIM) begin
			r = MIN_DIM;
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [SUM_W:0] v);
		logic [PIX_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed((SUM_W+1)'(255))) begin
			r = '1;
		end else begin
			r = v[PIX_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/sem_isqrt.sv @@
module sem_isqrt
	import sem_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam logic [RAD_W-1:0] FIRST_BIT = RAD_W'(1) << (2 * (ROOT_W - 1));

	logic             busy_q;
	logic             done_q;
	logic [RAD_W-1:0] rem_q;
	logic [RAD_W-1:0] res_q;
	logic [RAD_W-1:0] bit_q;
	logic [RAD_W-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == RAD_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= FIRST_BIT;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];

endmodule

@@ hw/rtl/sem_dp.sv @@
module sem_dp
	import sem_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic [PIX_W-1:0]     pixel,
	output logic [PIX_W-1:0]     magnitude,
	output logic [COORD_W-1:0]   out_row,
	output logic [COORD_W-1:0]   out_col
);

	logic [PIX_W-1:0] above_mem [MAX_WIDTH];
	logic [PIX_W-1:0] two_mem   [MAX_WIDTH];

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [PIX_W-1:0] px_q;
	logic [PIX_W-1:0] top_q;
	logic [PIX_W-1:0] mid_q;
	logic [PIX_W-1:0] win_q [9];

	logic [ROW_W-1:0] orow_q;
	logic [COL_W-1:0] ocol_q;
	logic             interior_q;

	logic [PIX_W-1:0] gh_q;
	logic [PIX_W-1:0] gv_q;
	logic [SQ_W-1:0]  sqh_q;
	logic [SQ_W-1:0]  sqv_q;

	logic [PIX_W-1:0]   mag_q;
	logic [COORD_W-1:0] row_out_q;
	logic [COORD_W-1:0] col_out_q;

	logic              emit;
	logic              interior;
	logic [DIM_W-1:0]  col_next;
	logic [DIM_W-1:0]  row_next;
	logic [SUM_W-1:0]  left;
	logic [SUM_W-1:0]  right;
	logic [SUM_W-1:0]  upper;
	logic [SUM_W-1:0]  lower;
	logic signed [SUM_W:0] dh;
	logic signed [SUM_W:0] dv;
	logic [RAD_W-1:0]  radicand;
	logic              root_done;
	logic [ROOT_W-1:0] root;

	assign emit = (col_q != '0 && row_q != '0) || (col_q == '0 && row_q >= ROW_W'(2));
	assign interior = row_q >= ROW_W'(2) && col_q >= COL_W'(2);
	assign col_next = DIM_W'(col_q) + DIM_W'(1);
	assign row_next = DIM_W'(row_q) + DIM_W'(1);

	assign sts.emit      = emit;
	assign sts.interior  = interior;
	assign sts.root_done = root_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(MAX_WIDTH);
			height_q <= DIM_W'(MAX_HEIGHT);
			col_q    <= '0;
			row_q    <= '0;
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (cmd.cfg_wr) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH:  width_q  <= eff_dim(cfg_data, DIM_W'(MAX_WIDTH));
					CFG_IMAGE_HEIGHT: height_q <= eff_dim(cfg_data, DIM_W'(MAX_HEIGHT));
					default: ;
				endcase
				col_q <= '0;
				row_q <= '0;
			end else if (cmd.upd) begin
				for (int k = 0; k < 3; k++) begin
					win_q[k*3+0] <= win_q[k*3+1];
					win_q[k*3+1] <= win_q[k*3+2];
				end
				win_q[2] <= top_q;
				win_q[5] <= mid_q;
				win_q[8] <= px_q;
				if (col_next >= width_q) begin
					col_q <= '0;
					if (row_next >= height_q) begin
						row_q <= '0;
					end else begin
						row_q <= row_next[ROW_W-1:0];
					end
				end else begin
					col_q <= col_next[COL_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			px_q  <= pixel;
			top_q <= two_mem[col_q];
			mid_q <= above_mem[col_q];
		end
		if (cmd.upd) begin
			two_mem[col_q]   <= mid_q;
			above_mem[col_q] <= px_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			interior_q <= interior;
			if (col_q != '0) begin
				orow_q <= row_q - ROW_W'(1);
				ocol_q <= col_q - COL_W'(1);
			end else begin
				orow_q <= row_q - ROW_W'(2);
				ocol_q <= COL_W'(width_q - DIM_W'(1));
			end
		end
	end

	assign left  = SUM_W'(win_q[0]) + (SUM_W'(win_q[3]) << 1) + SUM_W'(win_q[6]);
	assign right = SUM_W'(win_q[2]) + (SUM_W'(win_q[5]) << 1) + SUM_W'(win_q[8]);
	assign upper = SUM_W'(win_q[0]) + (SUM_W'(win_q[1]) << 1) + SUM_W'(win_q[2]);
	assign lower = SUM_W'(win_q[6]) + (SUM_W'(win_q[7]) << 1) + SUM_W'(win_q[8]);
	assign dh = $signed({1'b0, left}) - $signed({1'b0, right});
	assign dv = $signed({1'b0, lower}) - $signed({1'b0, upper});

	always_ff @(posedge clk) begin
		if (cmd.grad) begin
			gh_q <= clamp_pix(dh);
			gv_q <= clamp_pix(dv);
		end
		if (cmd.square) begin
			sqh_q <= gh_q * gh_q;
			sqv_q <= gv_q * gv_q;
		end
	end

	assign radicand = RAD_W'(sqh_q) + RAD_W'(sqv_q);

	sem_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.root_start),
		.radicand (radicand),
		.done     (root_done),
		.root     (root)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (!interior_q) begin
				mag_q <= '0;
			end else if (root > ROOT_W'(255)) begin
				mag_q <= '1;
			end else begin
				mag_q <= root[PIX_W-1:0];
			end
			row_out_q <= COORD_W'(orow_q);
			col_out_q <= COORD_W'(ocol_q);
		end
	end

	assign magnitude = mag_q;
	assign out_row   = row_out_q;
	assign out_col   = col_out_q;

endmodule

@@ hw/rtl/sem_ctrl.sv @@
module sem_ctrl
	import sem_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic cfg_valid,
	output logic cfg_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		cfg_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cfg_ready  = 1'b1;
				cmd.cfg_wr = cfg_valid;
				cmd.take   = in_valid && !cfg_valid;
				if (cmd.take) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				cmd.upd = 1'b1;
				if (!sts.emit) begin
					state_d = S_IDLE;
				end else if (sts.interior) begin
					state_d = S_GRAD;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_GRAD: begin
				cmd.grad = 1'b1;
				state_d  = S_SQUARE;
			end
			S_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = S_START;
			end
			S_START: begin
				cmd.root_start = 1'b1;
				state_d        = S_ROOT;
			end
			S_ROOT: begin
				if (sts.root_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (state_q == S_IDLE) begin
			in_ready = !cfg_valid;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ hw/rtl/sobel_edge_magnitude.sv @@
// Streaming 3x3 Sobel edge magnitude over 8-bit grey pixels in raster order.
// Channels: pixel requests on in_valid/in_ready, results (magnitude, out_row,
// out_col) on out_valid/out_ready, and register writes on cfg_valid/cfg_ready
// with cfg_index 0 = image_width, 1 = image_height. Write registers only while
// the block is idle; any write restarts the frame at row 0, column 0.
// Each pixel completes the result for the position one row plus one column
// behind it; the first image_width+1 pixels of a frame give no result, and
// border positions give magnitude 0.
// Steps per pixel: memory read and window update when no result is due; a
// border result adds the output load, and an interior result runs gradient,
// squares, root start and the bit-serial square root unit before that load.
// Results go to an output register; the next pixel is taken while a result
// still waits. When the receiver stalls, the following result holds in the
// datapath and no further pixel is taken until the output register frees.
// Reset: dimensions return to 512x512, counters and window clear; line
// buffer contents are undefined and are rewritten within each frame.
module sobel_edge_magnitude
	import sem_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     pixel,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PIX_W-1:0]     magnitude,
	output logic [COORD_W-1:0]   out_row,
	output logic [COORD_W-1:0]   out_col
);

	cmd_t cmd;
	sts_t sts;

	sem_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sem_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel),
		.magnitude (magnitude),
		.out_row   (out_row),
		.out_col   (out_col)
	);

endmodule
